// File: hw/rtl/orle_pkg.sv
`default_nettype none
package orle_pkg;
  localparam int unsigned CapacityDef = 64;
  localparam int unsigned MaxResults = 64;

  typedef enum logic [3:0] {
    ACT_ADDFRONT = 4'd0,
    ACT_ADDBACK  = 4'd1,
    ACT_POPFRONT = 4'd2,
    ACT_POPBACK  = 4'd3,
    ACT_INSERT   = 4'd4,
    ACT_RETRIEVE = 4'd5,
    ACT_REMOVE   = 4'd6,
    ACT_UPDATE   = 4'd7,
    ACT_LISTALL  = 4'd8,
    ACT_HONOR    = 4'd9,
    ACT_PRUNE    = 4'd10,
    ACT_SIZE     = 4'd11
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_APPENDED = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] name_tag;
    logic [11:0] grade;
  } rec_t;
endpackage
`default_nettype wire

// File: hw/rtl/ordered_record_list_engine_core.sv
// Ordered record list engine.
// Input channel (in_valid/in_ready) carries one command: action, id, name tag,
// grade and position. The result channel (out_valid/out_ready) returns one or
// more results per command; out_last marks the final one.
// Records live packed in list order in one synchronous RAM (one read, one
// write port, registered read data). Lookups, removals and pruning move
// through the RAM one entry per cycle; an insert shifts one entry at a time,
// reading it and then writing it one place up. Listing sends one record per
// cycle while the receiver takes them. One command is in flight.
// Reset clears the state, the record count, the result valid flag and the
// pending-read flag; RAM contents are only read below the record count.
// When the receiver stalls, the result register holds and the scan waits;
// no result is lost or repeated. The next command is taken the cycle after
// the last result of the current one has been transferred.
`default_nettype none
module ordered_record_list_engine_core #(
  parameter int unsigned CAPACITY = orle_pkg::CapacityDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_action,
  input  wire logic signed [31:0] in_rec_id,
  input  wire logic [31:0] in_name_tag,
  input  wire logic [11:0] in_grade,
  input  wire logic signed [7:0] in_position,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic             out_has_record,
  output logic signed [31:0] out_out_id,
  output logic [31:0]      out_out_name_tag,
  output logic [11:0]      out_out_grade,
  output logic [6:0]       out_count,
  output logic             out_last
);
  import orle_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = (CW > 7) ? CW : 7;

  typedef enum logic [2:0] {
    S_IDLE, S_SHUP, S_SHDN, S_SCAN, S_EMIT, S_LAST, S_RESP
  } state_t;

  rec_t mem [CAPACITY];
  rec_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  rec_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;     // read pointer
  logic [CW-1:0] wp_r, wp_nxt;       // write pointer / target
  logic rd_pend_r, rd_pend_nxt;
  logic [CW:0] k_r, k_nxt;
  action_t act_r, act_nxt;
  rec_t new_r, new_nxt;
  logic [2:0] st_r, st_nxt;
  logic found_r, found_nxt;
  logic hold_v_r, hold_v_nxt;
  rec_t hold_r, hold_nxt;
  logic ov_r, ov_nxt;
  logic [2:0] o_st_r, o_st_nxt;
  logic o_has_r, o_has_nxt;
  rec_t o_rec_r, o_rec_nxt;
  logic o_last_r, o_last_nxt;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_status = o_st_r;
  assign out_has_record = o_has_r;
  assign out_out_id = o_rec_r.id;
  assign out_out_name_tag = o_rec_r.name_tag;
  assign out_out_grade = o_rec_r.grade;
  assign out_count = 7'(cnt_r);
  assign out_last = o_last_r;

  logic full;
  logic [PW-1:0] pos_w;
  logic out_free;
  assign full = (cnt_r >= CW'(CAPACITY));
  assign pos_w = PW'(in_position[6:0]);
  assign out_free = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    wp_nxt = wp_r;
    rd_pend_nxt = 1'b0;
    k_nxt = k_r;
    act_nxt = act_r;
    new_nxt = new_r;
    st_nxt = st_r;
    found_nxt = found_r;
    hold_v_nxt = hold_v_r;
    hold_nxt = hold_r;
    ov_nxt = ov_r && !out_ready;
    o_st_nxt = o_st_r;
    o_has_nxt = o_has_r;
    o_rec_nxt = o_rec_r;
    o_last_nxt = o_last_r;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = new_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt = action_t'(in_action);
          new_nxt.id = in_rec_id;
          new_nxt.name_tag = in_name_tag;
          new_nxt.grade = in_grade;
          st_nxt = ST_OK;
          found_nxt = 1'b0;
          hold_v_nxt = 1'b0;
          k_nxt = '0;
          idx_nxt = '0;
          wp_nxt = '0;
          state_nxt = S_RESP;
          case (in_action)
            ACT_ADDFRONT, ACT_ADDBACK, ACT_INSERT: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                if (in_action == ACT_ADDFRONT ||
                    (in_action == ACT_INSERT && (in_position[7] || in_position == 8'sd0))) begin
                  wp_nxt = '0;
                end else if (in_action == ACT_ADDBACK) begin
                  wp_nxt = cnt_r;
                end else if (pos_w >= PW'(cnt_r)) begin
                  wp_nxt = cnt_r;
                  st_nxt = ST_APPENDED;
                end else begin
                  wp_nxt = CW'(pos_w);
                end
                idx_nxt = cnt_r;
                state_nxt = S_SHUP;
              end
            end
            ACT_POPFRONT, ACT_POPBACK: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else if (in_action == ACT_POPBACK) begin
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                idx_nxt = CW'(1);
                wp_nxt = '0;
                state_nxt = S_SHDN;
              end
            end
            ACT_RETRIEVE, ACT_REMOVE, ACT_UPDATE, ACT_PRUNE: begin
              if (in_action == ACT_PRUNE && cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_LISTALL, ACT_HONOR: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      // shift entries [wp, cnt) up by one, top down, then write new record
      S_SHUP: begin
        if (rd_pend_r) begin
          wr_en = 1'b1;
          wr_addr = AW'(idx_r + 1'b1);
          wr_data = rd_data_r;
        end else if (idx_r > wp_r) begin
          rd_en = 1'b1;
          rd_addr = AW'(idx_r - 1'b1);
          idx_nxt = idx_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end else begin
          wr_en = 1'b1;
          wr_addr = AW'(wp_r);
          wr_data = new_r;
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_RESP;
        end
        if (rd_pend_r) begin
          rd_pend_nxt = 1'b0;
        end
      end
      // copy entries [idx, cnt) down to wp, then shrink count
      S_SHDN: begin
        if (rd_pend_r) begin
          wr_en = 1'b1;
          wr_addr = AW'(wp_r);
          wr_data = rd_data_r;
          wp_nxt = wp_r + 1'b1;
        end
        if (idx_r < cnt_r) begin
          rd_en = 1'b1;
          rd_addr = AW'(idx_r);
          idx_nxt = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r) begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = S_RESP;
        end
      end
      // search first match, or compact for prune
      S_SCAN: begin
        if (rd_pend_r) begin
          if (act_r == ACT_PRUNE) begin
            if (rd_data_r.grade >= new_r.grade) begin
              wr_en = 1'b1;
              wr_addr = AW'(wp_r);
              wr_data = rd_data_r;
              wp_nxt = wp_r + 1'b1;
            end
          end else if (rd_data_r.id == new_r.id) begin
            found_nxt = 1'b1;
          end
        end
        if (act_r != ACT_PRUNE && rd_pend_r && rd_data_r.id == new_r.id) begin
          case (act_r)
            ACT_RETRIEVE: begin
              o_rec_nxt = rd_data_r;
              state_nxt = S_RESP;
            end
            ACT_UPDATE: begin
              wr_en = 1'b1;
              wr_addr = AW'(idx_r - 1'b1);
              wr_data = rd_data_r;
              wr_data.grade = new_r.grade;
              state_nxt = S_RESP;
            end
            default: begin
              wp_nxt = idx_r - 1'b1;
              state_nxt = S_SHDN;
            end
          endcase
        end else if (idx_r < cnt_r) begin
          rd_en = 1'b1;
          rd_addr = AW'(idx_r);
          idx_nxt = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (!rd_pend_r || act_r == ACT_PRUNE) begin
          if (act_r == ACT_PRUNE) begin
            cnt_nxt = (rd_pend_r && rd_data_r.grade >= new_r.grade) ? wp_r + 1'b1 : wp_r;
          end else begin
            st_nxt = ST_NOTFOUND;
          end
          state_nxt = S_RESP;
        end
      end
      // hold each match until the next one, the end of the list or the result limit decides its last flag
      S_EMIT: begin
        if (rd_pend_r) begin
          if (act_r == ACT_LISTALL || rd_data_r.grade >= new_r.grade) begin
            if (!hold_v_r || out_free) begin
              if (hold_v_r) begin
                ov_nxt = 1'b1;
                o_st_nxt = ST_OK;
                o_has_nxt = 1'b1;
                o_rec_nxt = hold_r;
                o_last_nxt = 1'b0;
              end
              hold_v_nxt = 1'b1;
              hold_nxt = rd_data_r;
              k_nxt = k_r + 1'b1;
              if (idx_r >= cnt_r || 32'(k_r) + 32'd1 >= MaxResults) begin
                state_nxt = S_LAST;
              end
            end else begin
              rd_pend_nxt = 1'b1;
            end
          end else if (idx_r >= cnt_r) begin
            state_nxt = hold_v_r ? S_LAST : S_RESP;
          end
        end
        if (state_nxt == S_EMIT && !rd_pend_nxt && idx_r < cnt_r) begin
          rd_en = 1'b1;
          rd_addr = AW'(idx_r);
          idx_nxt = idx_r + 1'b1;
          rd_pend_nxt = 1'b1;
        end
      end
      S_LAST: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          o_st_nxt = ST_OK;
          o_has_nxt = 1'b1;
          o_rec_nxt = hold_r;
          o_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          o_st_nxt = st_r;
          o_has_nxt = (act_r == ACT_RETRIEVE) && found_r;
          if (act_r == ACT_RETRIEVE && !found_r) begin
            o_rec_nxt = '{id: 32'hFFFF_FFFF, name_tag: '0, grade: '0};
          end else if (!(act_r == ACT_RETRIEVE && found_r)) begin
            o_rec_nxt = '0;
          end
          o_last_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ov_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    idx_r <= idx_nxt;
    wp_r <= wp_nxt;
    k_r <= k_nxt;
    act_r <= act_nxt;
    new_r <= new_nxt;
    st_r <= st_nxt;
    found_r <= found_nxt;
    hold_v_r <= hold_v_nxt;
    hold_r <= hold_nxt;
    o_st_r <= o_st_nxt;
    o_has_r <= o_has_nxt;
    o_rec_r <= o_rec_nxt;
    o_last_r <= o_last_nxt;
  end
endmodule
`default_nettype wire
